// File: src/sfa_pkg.sv
// Package for the segment fit allocator: sizes, codes and table entry types.
// Used by the table RAM, the top level and the port checker.
`timescale 1ns / 1ps
package sfa_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int ADDR_BITS    = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int LEN_W        = ADDR_BITS + 1;
    localparam int ID_W         = 16;

    localparam logic [LEN_W-1:0] POOL_MAX = LEN_W'(1) << ADDR_BITS;
    localparam logic [ID_W-1:0]  ID_LAST  = '1;
    localparam logic [ID_W-1:0]  ID_FIRST = ID_W'(1);

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_NOID   = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic       MODE_ALLOC = 1'b0;
    localparam logic       MODE_FREE  = 1'b1;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_POOL   = 2'd1;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             free;
        logic [ID_W-1:0]  owner;
    } t_seg;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_seg             data;
    } t_wr;

endpackage

// File: src/sfa_table.sv
// Segment table RAM: one write port, one read port, registered read data.
// Depends on sfa_pkg.
`timescale 1ns / 1ps
module sfa_table (
    input  logic                    i_clk,
    input  sfa_pkg::t_wr            i_wr,
    input  logic [sfa_pkg::IDX_W-1:0] i_raddr,
    output sfa_pkg::t_seg           o_rdata
);
    import sfa_pkg::*;

    t_seg r_mem [MAX_SEGMENTS];
    t_seg r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/segment_fit_allocator_top.sv
// Segment fit allocator top level: request sequencer around the segment table.
// Depends on sfa_pkg and sfa_table.
`timescale 1ns / 1ps
// One request is worked at a time. The table sits in a single-port-read RAM,
// so each request walks it one entry per cycle: a search pass over the live
// segments, then for a split or merge a shift of the entries above the
// touched one (each moved entry is read, then written one place over), then
// a statistics pass over the live segments. Once the result is registered,
// the sequencer returns to idle and can take the next request. A configuration
// write takes priority over a request offered in the same cycle. Writing
// pool_size resets the table to one free segment and restarts ids at 1; the
// first cycle after reset or that write rebuilds entry 0 and holds off
// requests for that cycle.
module segment_fit_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // req_size[16:0], owner_id[32:17], zero fill
    input  logic        i_s_tuser,   // mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // granted_id[15:0], used_total[32:16],
                                     // free_total[49:33], largest_free[66:50], zero fill
    output logic [1:0]  o_m_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import sfa_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_AEV    = 4'd2;
    localparam logic [3:0] S_SHR_RD = 4'd3;
    localparam logic [3:0] S_SHR_WR = 4'd4;
    localparam logic [3:0] S_AW0    = 4'd5;
    localparam logic [3:0] S_AW1    = 4'd6;
    localparam logic [3:0] S_FNX    = 4'd7;
    localparam logic [3:0] S_FNW    = 4'd8;
    localparam logic [3:0] S_FAP    = 4'd9;
    localparam logic [3:0] S_SHL_RD = 4'd10;
    localparam logic [3:0] S_SHL_WR = 4'd11;
    localparam logic [3:0] S_STAT   = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    logic [3:0]       r_state;
    logic             r_init;
    logic [1:0]       r_pol;
    logic [LEN_W-1:0] r_pool;
    logic [CNT_W-1:0] r_cnt;
    logic [ID_W-1:0]  r_id;

    logic             r_mode;
    logic [LEN_W-1:0] r_size;
    logic [ID_W-1:0]  r_oid;

    logic [CNT_W-1:0] r_a;
    logic             r_v;
    logic [IDX_W-1:0] r_ri;
    logic             r_fnd;
    logic [IDX_W-1:0] r_sel;
    logic [LEN_W-1:0] r_slen;
    logic             r_pf;
    logic [LEN_W-1:0] r_pl;
    logic             r_nf;
    logic [LEN_W-1:0] r_nl;
    logic [CNT_W-1:0] r_ptr;
    logic [1:0]       r_gap;

    logic [1:0]       r_status;
    logic [ID_W-1:0]  r_gid;
    logic [LEN_W-1:0] r_used;
    logic [LEN_W-1:0] r_free;
    logic [LEN_W-1:0] r_lg;

    logic             r_ovalid;
    logic [71:0]      r_odata;
    logic [1:0]       r_ouser;

    t_wr              w_wr;
    logic [IDX_W-1:0] w_raddr;
    t_seg             w_rd;
    logic             w_issue;
    logic             w_fit;
    logic             w_take;
    logic             w_match;
    logic [LEN_W-1:0] w_cfg_pool;
    logic [ID_W-1:0]  w_id_next;
    logic [CNT_W-1:0] w_sel_c;

    sfa_table u_table (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign o_s_tready  = (r_state == S_IDLE) && !r_init && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tuser   = r_ouser;

    assign w_issue   = (r_a < r_cnt);
    assign w_id_next = (r_id == ID_LAST) ? ID_FIRST : r_id + ID_W'(1);
    assign w_sel_c   = {1'b0, r_sel};
    assign w_fit     = w_rd.free && (w_rd.len >= r_size);
    assign w_match   = !w_rd.free && (w_rd.owner == r_oid);

    always_comb begin
        w_cfg_pool = i_cfg_data;
        if (w_cfg_pool == '0) begin
            w_cfg_pool = LEN_W'(1);
        end else if (w_cfg_pool > POOL_MAX) begin
            w_cfg_pool = POOL_MAX;
        end
    end

    always_comb begin
        case (r_pol)
            POL_BEST:  w_take = !r_fnd || (w_rd.len < r_slen);
            POL_WORST: w_take = !r_fnd || (w_rd.len > r_slen);
            default:   w_take = !r_fnd;
        endcase
    end

    always_comb begin
        w_wr    = '0;
        w_raddr = r_a[IDX_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                w_wr.we   = r_init;
                w_wr.addr = '0;
                w_wr.data = '{len: r_pool, free: 1'b1, owner: '0};
            end
            S_AEV: begin
                w_wr.we   = r_fnd && (r_slen == r_size);
                w_wr.addr = r_sel;
                w_wr.data = '{len: r_size, free: 1'b0, owner: r_id};
            end
            S_SHR_RD: begin
                w_raddr = IDX_W'(r_ptr - CNT_W'(1));
            end
            S_SHR_WR: begin
                w_wr.we   = 1'b1;
                w_wr.addr = r_ptr[IDX_W-1:0];
                w_wr.data = w_rd;
            end
            S_AW0: begin
                w_wr.we   = 1'b1;
                w_wr.addr = r_sel;
                w_wr.data = '{len: r_size, free: 1'b0, owner: r_id};
            end
            S_AW1: begin
                w_wr.we   = 1'b1;
                w_wr.addr = r_sel + IDX_W'(1);
                w_wr.data = '{len: r_slen - r_size, free: 1'b1, owner: '0};
            end
            S_FNX: begin
                w_raddr = r_sel + IDX_W'(1);
            end
            S_FAP: begin
                w_wr.we        = 1'b1;
                w_wr.data.free = 1'b1;
                if (r_pf) begin
                    w_wr.addr     = r_sel - IDX_W'(1);
                    w_wr.data.len = r_pl + r_slen + (r_nf ? r_nl : '0);
                end else begin
                    w_wr.addr     = r_sel;
                    w_wr.data.len = r_slen + (r_nf ? r_nl : '0);
                end
            end
            S_SHL_RD: begin
                w_raddr = r_ptr[IDX_W-1:0];
            end
            S_SHL_WR: begin
                w_wr.we   = 1'b1;
                w_wr.addr = IDX_W'(r_ptr - CNT_W'(r_gap));
                w_wr.data = w_rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_init   <= 1'b1;
            r_pol    <= POL_FIRST;
            r_pool   <= POOL_MAX;
            r_cnt    <= CNT_W'(1);
            r_id     <= ID_FIRST;
            r_ovalid <= 1'b0;
            r_v      <= 1'b0;
        end else begin
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (r_init) begin
                        r_init <= 1'b0;
                    end else if (i_s_tvalid && o_s_tready) begin
                        r_mode  <= i_s_tuser;
                        r_size  <= i_s_tdata[16:0];
                        r_oid   <= i_s_tdata[32:17];
                        r_a     <= '0;
                        r_v     <= 1'b0;
                        r_fnd   <= 1'b0;
                        r_pf    <= 1'b0;
                        r_gid   <= '0;
                        r_state <= S_SCAN;
                    end
                    if (i_cfg_valid) begin
                        if (i_cfg_index == REG_POLICY) begin
                            r_pol <= i_cfg_data[1:0];
                        end else if (i_cfg_index == REG_POOL) begin
                            r_pool <= w_cfg_pool;
                            r_cnt  <= CNT_W'(1);
                            r_id   <= ID_FIRST;
                            r_init <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    r_v  <= w_issue;
                    r_ri <= r_a[IDX_W-1:0];
                    if (w_issue) begin
                        r_a <= r_a + CNT_W'(1);
                    end
                    if (r_mode == MODE_ALLOC) begin
                        if (r_v && w_fit && w_take) begin
                            r_fnd  <= 1'b1;
                            r_sel  <= r_ri;
                            r_slen <= w_rd.len;
                        end
                        if (!w_issue && !r_v) begin
                            r_state <= S_AEV;
                        end
                    end else begin
                        if (r_v && w_match) begin
                            r_sel   <= r_ri;
                            r_slen  <= w_rd.len;
                            r_v     <= 1'b0;
                            r_state <= S_FNX;
                        end else begin
                            if (r_v) begin
                                r_pf <= w_rd.free;
                                r_pl <= w_rd.len;
                            end
                            if (!w_issue && !r_v) begin
                                r_status <= ST_NOID;
                                r_a      <= '0;
                                r_used   <= '0;
                                r_free   <= '0;
                                r_lg     <= '0;
                                r_state  <= S_STAT;
                            end
                        end
                    end
                end
                S_AEV: begin
                    r_ptr <= r_cnt;
                    if (!r_fnd) begin
                        r_status <= ST_NOFIT;
                    end else if (r_slen == r_size) begin
                        r_status <= ST_OK;
                        r_gid    <= r_id;
                        r_id     <= w_id_next;
                    end else if (r_cnt == CNT_W'(MAX_SEGMENTS)) begin
                        r_status <= ST_FULL;
                    end
                    if (r_fnd && (r_slen != r_size) && (r_cnt != CNT_W'(MAX_SEGMENTS))) begin
                        r_state <= S_SHR_RD;
                    end else begin
                        r_a     <= '0;
                        r_used  <= '0;
                        r_free  <= '0;
                        r_lg    <= '0;
                        r_state <= S_STAT;
                    end
                end
                S_SHR_RD: begin
                    if (r_ptr >= w_sel_c + CNT_W'(2)) begin
                        r_state <= S_SHR_WR;
                    end else begin
                        r_state <= S_AW0;
                    end
                end
                S_SHR_WR: begin
                    r_ptr   <= r_ptr - CNT_W'(1);
                    r_state <= S_SHR_RD;
                end
                S_AW0: begin
                    r_state <= S_AW1;
                end
                S_AW1: begin
                    r_cnt    <= r_cnt + CNT_W'(1);
                    r_status <= ST_OK;
                    r_gid    <= r_id;
                    r_id     <= w_id_next;
                    r_a      <= '0;
                    r_used   <= '0;
                    r_free   <= '0;
                    r_lg     <= '0;
                    r_state  <= S_STAT;
                end
                S_FNX: begin
                    if (w_sel_c + CNT_W'(1) < r_cnt) begin
                        r_state <= S_FNW;
                    end else begin
                        r_nf    <= 1'b0;
                        r_state <= S_FAP;
                    end
                end
                S_FNW: begin
                    r_nf    <= w_rd.free;
                    r_nl    <= w_rd.len;
                    r_state <= S_FAP;
                end
                S_FAP: begin
                    r_status <= ST_OK;
                    r_gap    <= {1'b0, r_pf} + {1'b0, r_nf};
                    if (r_pf && r_nf) begin
                        r_ptr <= w_sel_c + CNT_W'(2);
                    end else if (r_pf) begin
                        r_ptr <= w_sel_c + CNT_W'(1);
                    end else if (r_nf) begin
                        r_ptr <= w_sel_c + CNT_W'(2);
                    end else begin
                        r_ptr <= r_cnt;
                    end
                    r_state <= S_SHL_RD;
                end
                S_SHL_RD: begin
                    if (r_ptr < r_cnt) begin
                        r_state <= S_SHL_WR;
                    end else begin
                        r_cnt   <= r_cnt - CNT_W'(r_gap);
                        r_a     <= '0;
                        r_used  <= '0;
                        r_free  <= '0;
                        r_lg    <= '0;
                        r_state <= S_STAT;
                    end
                end
                S_SHL_WR: begin
                    r_ptr   <= r_ptr + CNT_W'(1);
                    r_state <= S_SHL_RD;
                end
                S_STAT: begin
                    r_v <= w_issue;
                    if (w_issue) begin
                        r_a <= r_a + CNT_W'(1);
                    end
                    if (r_v) begin
                        if (w_rd.free) begin
                            r_free <= r_free + w_rd.len;
                            if (w_rd.len > r_lg) begin
                                r_lg <= w_rd.len;
                            end
                        end else begin
                            r_used <= r_used + w_rd.len;
                        end
                    end
                    if (!w_issue && !r_v) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_ouser  <= r_status;
                        r_odata  <= {5'd0, r_lg, r_free, r_used, r_gid};
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/sfa_checker.sv
// Port-level checker for the segment fit allocator, bound to the top level.
// Depends on sfa_pkg.
`timescale 1ns / 1ps
module sfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);
    import sfa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while another is in work");

    a_gid_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_OK) |-> (o_m_tdata[15:0] == '0))
        else $error("id granted on a failed transaction");

    a_largest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[66:50] <= o_m_tdata[49:33]))
        else $error("largest free segment above free total");

    a_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ({1'b0, o_m_tdata[32:16]} + {1'b0, o_m_tdata[49:33]}
                        <= {1'b0, POOL_MAX}))
        else $error("used plus free exceeds the pool");

endmodule

bind segment_fit_allocator_top sfa_checker u_sfa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
